// ----- src/stp_pkg.sv -----
// Package of shared types, constants and functions for the SysEx tally poller.
`timescale 1ns / 1ps

package stp_pkg;

  // Number of tally channels and the width of a channel index.
  localparam int NUM_CHANNELS = 8;
  localparam int CH_W         = $clog2(NUM_CHANNELS);

  // Width of the signed on-air index and of the relay drive.
  localparam int ON_AIR_W = 4;
  localparam int RELAY_W  = 8;

  // Command queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // SysEx framing and message bytes.
  localparam logic [7:0] SYX_START = 8'hF0;
  localparam logic [7:0] SYX_END   = 8'hF7;
  localparam logic [7:0] MFR_ID    = 8'h41;
  localparam logic [7:0] MODEL_ID  = 8'h68;
  localparam logic [7:0] CMD_RQ1   = 8'h11;
  localparam logic [7:0] CMD_DT1   = 8'h12;
  localparam logic [7:0] ADDR_HI   = 8'h0C;
  localparam logic [7:0] SIZE_LO   = 8'h08;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [7:0] STATUS_ON = 8'h01;

  // Byte positions within a received frame (F0 is position 0).
  localparam logic [4:0] CMD_POS       = 5'd7;
  localparam logic [4:0] CH_POS        = 5'd10;
  localparam logic [4:0] STAT_POS      = 5'd11;
  localparam logic [4:0] REPLY_MIN_POS = 5'd11;
  localparam logic [4:0] POS_MAX       = 5'd31;

  // Last byte index of a request run.
  localparam logic [3:0] REQ_LAST_IDX = 4'd15;

  // Reset values of the configuration registers.
  localparam logic [6:0] DEVICE_ID_RST        = 7'd16;
  localparam logic       RELAY_ACTIVE_LOW_RST = 1'b1;

  // On-air index meaning no channel.
  localparam logic signed [ON_AIR_W-1:0] ON_AIR_NONE = -4'sd1;

  // Result kinds.
  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_UPDATE  = 1'b1;

  // Input item functions.
  localparam logic FUNC_POLL = 1'b0;
  localparam logic FUNC_RX   = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEVICE_ID        = 2'd0,
    CFG_RELAY_ACTIVE_LOW = 2'd1
  } cfg_reg_t;

  // Back end sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_REQ
  } back_state_t;

  // One command passed from the front to the back.
  typedef struct packed {
    logic            is_update;
    logic [CH_W-1:0] channel;
    logic [7:0]      status;
  } q_entry_t;

  // Byte idx of the request message for channel ch.
  function automatic logic [7:0] req_byte(input logic [3:0]      idx,
                                          input logic [6:0]      dev_id,
                                          input logic [CH_W-1:0] ch);
    logic [6:0] sum7;
    logic [6:0] ck;
    logic [7:0] b;
    sum7 = 7'(ADDR_HI) + 7'(SIZE_LO) + 7'(ch);
    ck   = ~sum7 + 7'd1;
    unique case (idx)
      4'd0:  b = SYX_START;
      4'd1:  b = MFR_ID;
      4'd2:  b = {1'b0, dev_id};
      4'd3:  b = ZERO_BYTE;
      4'd4:  b = ZERO_BYTE;
      4'd5:  b = ZERO_BYTE;
      4'd6:  b = MODEL_ID;
      4'd7:  b = CMD_RQ1;
      4'd8:  b = ADDR_HI;
      4'd9:  b = ZERO_BYTE;
      4'd10: b = 8'(ch);
      4'd11: b = ZERO_BYTE;
      4'd12: b = ZERO_BYTE;
      4'd13: b = SIZE_LO;
      4'd14: b = {1'b0, ck};
      4'd15: b = SYX_END;
    endcase
    return b;
  endfunction

endpackage

// ----- src/stp_in_if.sv -----
// Input channel interface: poll ticks and received MIDI bytes.
`timescale 1ns / 1ps

interface stp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, func, rx_byte, input ready);
  modport sink   (input valid, func, rx_byte, output ready);
endinterface

// ----- src/stp_out_if.sv -----
// Result channel interface: request bytes and relay updates.
`timescale 1ns / 1ps

interface stp_out_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [7:0]                          tx_byte;
  logic                                last;
  logic [stp_pkg::RELAY_W-1:0]         relay_drive;
  logic signed [stp_pkg::ON_AIR_W-1:0] on_air;

  modport source (output valid, kind, tx_byte, last, relay_drive, on_air, input ready);
  modport sink   (input valid, kind, tx_byte, last, relay_drive, on_air, output ready);
endinterface

// ----- src/stp_cfg_if.sv -----
// Configuration write channel interface.
`timescale 1ns / 1ps

interface stp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [stp_pkg::CFG_IDX_W-1:0]  index;
  logic [stp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/stp_front.sv -----
// Front end: accepts transactions, frames received SysEx and queues commands.
`timescale 1ns / 1ps

module stp_front (
  input  logic              clk,
  input  logic              rst_n,
  stp_in_if.sink            in_if,
  input  logic              q_full,
  output logic              q_push,
  output stp_pkg::q_entry_t q_push_data
);

  logic [stp_pkg::CH_W-1:0] poll_r, poll_nxt;
  logic                     in_msg_r, in_msg_nxt;
  logic [4:0]               pos_r, pos_nxt;
  logic [7:0]               cmd_r, cmd_nxt;
  logic [7:0]               rch_r, rch_nxt;
  logic [7:0]               rstat_r, rstat_nxt;
  logic [7:0]               final_status;
  logic                     accept;

  // An item is taken whenever the queue has room for the command it may cause.
  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && in_if.ready;

  // Classify the transaction, advance the framer and build any command.
  always_comb begin
    poll_nxt     = poll_r;
    in_msg_nxt   = in_msg_r;
    pos_nxt      = pos_r;
    cmd_nxt      = cmd_r;
    rch_nxt      = rch_r;
    rstat_nxt    = rstat_r;
    q_push       = 1'b0;
    q_push_data  = '0;
    final_status = (pos_r == stp_pkg::STAT_POS) ? in_if.rx_byte : rstat_r;

    if (accept) begin
      if (in_if.func == stp_pkg::FUNC_POLL) begin
        // Poll tick: request for the current channel, then move on.
        q_push              = 1'b1;
        q_push_data.channel = poll_r;
        if (poll_r == stp_pkg::CH_W'(stp_pkg::NUM_CHANNELS - 1)) begin
          poll_nxt = '0;
        end else begin
          poll_nxt = poll_r + 1'b1;
        end
      end else if (in_if.rx_byte == stp_pkg::SYX_START) begin
        // Start of frame restarts the parse even inside a frame.
        in_msg_nxt = 1'b1;
        pos_nxt    = 5'd1;
        cmd_nxt    = '0;
        rch_nxt    = '0;
        rstat_nxt  = '0;
      end else if (in_msg_r) begin
        if (in_if.rx_byte == stp_pkg::SYX_END) begin
          // End of frame: hand a well-formed reply to the back end.
          if (cmd_r == stp_pkg::CMD_DT1 && pos_r >= stp_pkg::REPLY_MIN_POS &&
              rch_r < 8'(stp_pkg::NUM_CHANNELS)) begin
            q_push                = 1'b1;
            q_push_data.is_update = 1'b1;
            q_push_data.channel   = rch_r[stp_pkg::CH_W-1:0];
            q_push_data.status    = final_status;
          end
          in_msg_nxt = 1'b0;
          pos_nxt    = '0;
        end else begin
          // Data byte: keep the fields of interest.
          priority if (pos_r == stp_pkg::CMD_POS) begin
            cmd_nxt = in_if.rx_byte;
          end else if (pos_r == stp_pkg::CH_POS) begin
            rch_nxt = in_if.rx_byte;
          end else if (pos_r == stp_pkg::STAT_POS) begin
            rstat_nxt = in_if.rx_byte;
          end else begin
            cmd_nxt = cmd_r;
          end
          if (pos_r != stp_pkg::POS_MAX) begin
            pos_nxt = pos_r + 5'd1;
          end
        end
      end
    end
  end

  // Framer and poll channel registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_r   <= '0;
      in_msg_r <= 1'b0;
      pos_r    <= '0;
      cmd_r    <= '0;
      rch_r    <= '0;
      rstat_r  <= '0;
    end else begin
      poll_r   <= poll_nxt;
      in_msg_r <= in_msg_nxt;
      pos_r    <= pos_nxt;
      cmd_r    <= cmd_nxt;
      rch_r    <= rch_nxt;
      rstat_r  <= rstat_nxt;
    end
  end

endmodule

// ----- src/stp_queue.sv -----
// Short command queue between the front and the back.
`timescale 1ns / 1ps

module stp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  stp_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output stp_pkg::q_entry_t head_data
);

  stp_pkg::q_entry_t          mem_r [stp_pkg::QDEPTH];
  logic [stp_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [stp_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [stp_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == stp_pkg::QCNT_W'(stp_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      if (wr_ptr_r == stp_pkg::QPTR_W'(stp_pkg::QDEPTH - 1)) begin
        wr_ptr_nxt = '0;
      end else begin
        wr_ptr_nxt = wr_ptr_r + 1'b1;
      end
    end
    if (pop) begin
      if (rd_ptr_r == stp_pkg::QPTR_W'(stp_pkg::QDEPTH - 1)) begin
        rd_ptr_nxt = '0;
      end else begin
        rd_ptr_nxt = rd_ptr_r + 1'b1;
      end
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("command queue read while empty");

endmodule

// ----- src/stp_back.sv -----
// Back end: plays out request runs and applies status replies to the tally table.
`timescale 1ns / 1ps

module stp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  stp_pkg::q_entry_t q_data,
  output logic              q_pop,
  input  logic [6:0]        device_id,
  input  logic              relay_active_low,
  stp_out_if.source         out_if
);

  stp_pkg::back_state_t      state_r, state_nxt;
  logic [3:0]                idx_r, idx_nxt;
  logic [stp_pkg::CH_W-1:0]  req_ch_r, req_ch_nxt;

  logic [7:0]                stat_r [stp_pkg::NUM_CHANNELS];
  logic [7:0]                stat_nxt [stp_pkg::NUM_CHANNELS];
  logic [stp_pkg::NUM_CHANNELS-1:0] known_r, known_nxt;
  logic signed [3:0]         on_air_r, on_air_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_kind_r, out_kind_nxt;
  logic [7:0]                out_tx_r, out_tx_nxt;
  logic                      out_last_r, out_last_nxt;
  logic [7:0]                out_drive_r, out_drive_nxt;
  logic signed [3:0]         out_air_r, out_air_nxt;

  logic                      can_load;
  logic                      changed;
  logic                      found;
  logic [3:0]                hit;
  logic [7:0]                onbit;
  logic [7:0]                drive;

  assign can_load = !out_valid_r || out_if.ready;

  assign out_if.valid       = out_valid_r;
  assign out_if.kind        = out_kind_r;
  assign out_if.tx_byte     = out_tx_r;
  assign out_if.last        = out_last_r;
  assign out_if.relay_drive = out_drive_r;
  assign out_if.on_air      = out_air_r;

  // Sequencer, tally table update and result register loading.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    req_ch_nxt    = req_ch_r;
    known_nxt     = known_r;
    on_air_nxt    = on_air_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_kind_nxt  = out_kind_r;
    out_tx_nxt    = out_tx_r;
    out_last_nxt  = out_last_r;
    out_drive_nxt = out_drive_r;
    out_air_nxt   = out_air_r;
    q_pop         = 1'b0;
    found         = 1'b0;
    hit           = '0;
    onbit         = '0;
    drive         = '0;
    for (int t = 0; t < stp_pkg::NUM_CHANNELS; t++) begin
      stat_nxt[t] = stat_r[t];
    end
    changed = !known_r[q_data.channel] || (stat_r[q_data.channel] != q_data.status);

    unique case (state_r)
      stp_pkg::BK_IDLE: begin
        if (q_valid && can_load) begin
          q_pop = 1'b1;
          if (!q_data.is_update) begin
            // First byte of a request run goes out at once.
            out_valid_nxt = 1'b1;
            out_kind_nxt  = stp_pkg::KIND_REQUEST;
            out_tx_nxt    = stp_pkg::req_byte(4'd0, device_id, q_data.channel);
            out_last_nxt  = 1'b0;
            out_drive_nxt = '0;
            out_air_nxt   = '0;
            req_ch_nxt    = q_data.channel;
            idx_nxt       = 4'd1;
            state_nxt     = stp_pkg::BK_REQ;
          end else if (changed) begin
            // Store the status and find the highest channel that is on air.
            stat_nxt[q_data.channel]  = q_data.status;
            known_nxt[q_data.channel] = 1'b1;
            for (int t = 0; t < stp_pkg::NUM_CHANNELS; t++) begin
              if (stat_nxt[t] == stp_pkg::STATUS_ON) begin
                found = 1'b1;
                hit   = 4'(t);
              end
            end
            if (found) begin
              on_air_nxt = $signed(hit);
            end
            if (!on_air_nxt[3]) begin
              onbit = 8'd1 << on_air_nxt[2:0];
            end
            drive         = relay_active_low ? ~onbit : onbit;
            out_valid_nxt = 1'b1;
            out_kind_nxt  = stp_pkg::KIND_UPDATE;
            out_tx_nxt    = '0;
            out_last_nxt  = 1'b1;
            out_drive_nxt = drive;
            out_air_nxt   = on_air_nxt;
          end
        end
      end
      stp_pkg::BK_REQ: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = stp_pkg::KIND_REQUEST;
          out_tx_nxt    = stp_pkg::req_byte(idx_r, device_id, req_ch_r);
          out_last_nxt  = (idx_r == stp_pkg::REQ_LAST_IDX);
          out_drive_nxt = '0;
          out_air_nxt   = '0;
          idx_nxt       = idx_r + 4'd1;
          if (idx_r == stp_pkg::REQ_LAST_IDX) begin
            state_nxt = stp_pkg::BK_IDLE;
          end
        end
      end
    endcase
  end

  // Control, tally table and result valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stp_pkg::BK_IDLE;
      idx_r       <= '0;
      known_r     <= '0;
      on_air_r    <= stp_pkg::ON_AIR_NONE;
      out_valid_r <= 1'b0;
      for (int t = 0; t < stp_pkg::NUM_CHANNELS; t++) begin
        stat_r[t] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      known_r     <= known_nxt;
      on_air_r    <= on_air_nxt;
      out_valid_r <= out_valid_nxt;
      for (int t = 0; t < stp_pkg::NUM_CHANNELS; t++) begin
        stat_r[t] <= stat_nxt[t];
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    req_ch_r    <= req_ch_nxt;
    out_kind_r  <= out_kind_nxt;
    out_tx_r    <= out_tx_nxt;
    out_last_r  <= out_last_nxt;
    out_drive_r <= out_drive_nxt;
    out_air_r   <= out_air_nxt;
  end

  a_req_idx_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stp_pkg::BK_REQ) |-> (idx_r != 4'd0))
    else $error("request run in progress with byte index zero");

  a_update_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == stp_pkg::KIND_UPDATE) |-> out_last_r)
    else $error("relay update not marked last");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stp_pkg::BK_REQ && can_load && idx_r == stp_pkg::REQ_LAST_IDX) |=>
    (state_r == stp_pkg::BK_IDLE && out_valid_r && out_last_r))
    else $error("request run did not close on its final byte");

  a_no_pop_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stp_pkg::BK_REQ) |-> !q_pop)
    else $error("command taken while a request run is playing");

endmodule

// ----- src/sysex_tally_poll_decoder_top.sv -----
// Top level of the SysEx tally poller: configuration registers, front, queue and back.
// A transaction's first result passes through the command queue and the result register.
// Throughput: a poll tick holds the back end for 16 request bytes, one a cycle while the
// receiver is ready; inputs are taken one a cycle while the 4-entry command queue has room.
// Reset (synchronous, rst_n low) clears framing, poll channel, tally table and queue,
// and sets on_air to -1, device_id to 16 and relay_active_low to 1.
`timescale 1ns / 1ps

module sysex_tally_poll_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  stp_in_if.sink     in_if,
  stp_out_if.source  out_if,
  stp_cfg_if.sink    cfg_if
);

  logic [6:0]        device_id_r, device_id_nxt;
  logic              relay_active_low_r, relay_active_low_nxt;

  logic              q_full;
  logic              q_push;
  stp_pkg::q_entry_t q_push_data;
  logic              q_pop;
  logic              q_valid;
  stp_pkg::q_entry_t q_head;

  // Configuration writes are always taken.
  assign cfg_if.ready = 1'b1;

  // Register file decode.
  always_comb begin
    device_id_nxt        = device_id_r;
    relay_active_low_nxt = relay_active_low_r;
    if (cfg_if.valid) begin
      unique case (stp_pkg::cfg_reg_t'(cfg_if.index))
        stp_pkg::CFG_DEVICE_ID:        device_id_nxt        = cfg_if.data[6:0];
        stp_pkg::CFG_RELAY_ACTIVE_LOW: relay_active_low_nxt = cfg_if.data[0];
        default:                       device_id_nxt        = device_id_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r        <= stp_pkg::DEVICE_ID_RST;
      relay_active_low_r <= stp_pkg::RELAY_ACTIVE_LOW_RST;
    end else begin
      device_id_r        <= device_id_nxt;
      relay_active_low_r <= relay_active_low_nxt;
    end
  end

  stp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  stp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  stp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (q_head),
    .q_pop            (q_pop),
    .device_id        (device_id_r),
    .relay_active_low (relay_active_low_r),
    .out_if           (out_if)
  );

endmodule

// ----- tb/sv/sysex_tally_poll_decoder_top_test.sv -----
// Self-checking testbench of the SysEx tally poller: directed table, then random framed traffic.
`timescale 1ns / 1ps

module sysex_tally_poll_decoder_top_test;

  // One result transaction as seen on the output channel.
  typedef struct packed {
    logic                                kind;
    logic [7:0]                          tx;
    logic                                last;
    logic [stp_pkg::RELAY_W-1:0]         drive;
    logic signed [stp_pkg::ON_AIR_W-1:0] air;
  } tally_result_t;

  // One row of the directed table; typed rows carry their relay update by hand.
  typedef struct packed {
    logic          func;
    logic [7:0]    rx;
    logic          typed;
    tally_result_t res;
  } dir_row_t;

  localparam int          DIR_ROWS    = 22;
  localparam int          SETTLE      = 40;
  localparam int          HOLD_OFF    = 400;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic [7:0]  MIDI_CLOCK  = 8'hF8;
  localparam logic [1:0]  CFG_SPARE_A = 2'd2;
  localparam logic [1:0]  CFG_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  stp_in_if  in_ch ();
  stp_out_if out_ch ();
  stp_cfg_if cfg_ch ();

  sysex_tally_poll_decoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #4 clk = ~clk;

  // Shadow copy of the poller and decoder state and its registers.
  logic [6:0]                   dev_id;
  logic                         act_low;
  logic [stp_pkg::CH_W-1:0]     poll_ch;
  logic                         in_msg;
  logic [4:0]                   byte_pos;
  logic [7:0]                   cmd_b;
  logic [7:0]                   rep_ch;
  logic [7:0]                   rep_st;
  logic [7:0]                   ch_status [stp_pkg::NUM_CHANNELS];
  logic                         ch_known  [stp_pkg::NUM_CHANNELS];
  logic [stp_pkg::ON_AIR_W-1:0] on_air_idx;

  tally_result_t step_results [$];
  tally_result_t pending_results [$];

  // Tags travelling with the offered input transaction.
  logic          cur_typed;
  tally_result_t cur_typed_res;

  int unsigned errors           = 0;
  int unsigned items_sent       = 0;
  int unsigned results_checked  = 0;
  int unsigned updates_expected = 0;
  int unsigned cfg_writes       = 0;
  int unsigned cycle_count      = 0;
  int          hold_req         = 0;
  int          burst_left       = 0;

  dir_row_t dir_table [DIR_ROWS];

  // Work out the results of one accepted input transaction.
  function automatic void tally_predict(input logic func, input logic [7:0] b);
    logic [7:0]    msg [16];
    logic [7:0]    sum;
    logic [7:0]    diff;
    logic [7:0]    onbit;
    logic [7:0]    ch;
    tally_result_t res;
    step_results.delete();
    if (func == stp_pkg::FUNC_POLL) begin
      sum  = stp_pkg::ADDR_HI + stp_pkg::ZERO_BYTE + 8'(poll_ch) + stp_pkg::ZERO_BYTE
             + stp_pkg::ZERO_BYTE + stp_pkg::SIZE_LO;
      diff = 8'd128 - {1'b0, sum[6:0]};
      msg = '{stp_pkg::SYX_START, stp_pkg::MFR_ID, {1'b0, dev_id}, stp_pkg::ZERO_BYTE,
              stp_pkg::ZERO_BYTE, stp_pkg::ZERO_BYTE, stp_pkg::MODEL_ID, stp_pkg::CMD_RQ1,
              stp_pkg::ADDR_HI, stp_pkg::ZERO_BYTE, 8'(poll_ch), stp_pkg::ZERO_BYTE,
              stp_pkg::ZERO_BYTE, stp_pkg::SIZE_LO, {1'b0, diff[6:0]}, stp_pkg::SYX_END};
      for (int i = 0; i < 16; i++) begin
        res          = '{stp_pkg::KIND_REQUEST, msg[i], (i == 15), 8'h00, 4'sd0};
        step_results = {step_results, res};
      end
      if (poll_ch == stp_pkg::CH_W'(stp_pkg::NUM_CHANNELS - 1)) poll_ch = '0;
      else poll_ch = poll_ch + 1'b1;
    end else if (b == stp_pkg::SYX_START) begin
      in_msg   = 1'b1;
      byte_pos = 5'd1;
      cmd_b    = 8'h00;
      rep_ch   = 8'h00;
      rep_st   = 8'h00;
    end else if (in_msg && b == stp_pkg::SYX_END) begin
      // An end byte in the status slot stands for the status as well.
      if (byte_pos == stp_pkg::STAT_POS) rep_st = b;
      if (cmd_b == stp_pkg::CMD_DT1 && byte_pos >= stp_pkg::REPLY_MIN_POS &&
          rep_ch < stp_pkg::NUM_CHANNELS) begin
        ch = rep_ch;
        if (!(ch_known[ch[stp_pkg::CH_W-1:0]] && ch_status[ch[stp_pkg::CH_W-1:0]] == rep_st))
        begin
          ch_status[ch[stp_pkg::CH_W-1:0]] = rep_st;
          ch_known[ch[stp_pkg::CH_W-1:0]]  = 1'b1;
          for (int t = 0; t < stp_pkg::NUM_CHANNELS; t++) begin
            if (ch_status[t] == stp_pkg::STATUS_ON) on_air_idx = stp_pkg::ON_AIR_W'(t);
          end
          onbit = (on_air_idx < 4'd8) ? (8'd1 << on_air_idx) : 8'd0;
          res   = '{stp_pkg::KIND_UPDATE, 8'h00, 1'b1, act_low ? ~onbit : onbit, on_air_idx};
          step_results = {step_results, res};
        end
      end
      in_msg   = 1'b0;
      byte_pos = 5'd0;
    end else if (in_msg) begin
      if (byte_pos == stp_pkg::CMD_POS) cmd_b = b;
      else if (byte_pos == stp_pkg::CH_POS) rep_ch = b;
      else if (byte_pos == stp_pkg::STAT_POS) rep_st = b;
      if (byte_pos < stp_pkg::POS_MAX) byte_pos = byte_pos + 1'b1;
    end
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Monitor: results against the oldest expectation, then predict new inputs.
  tally_result_t want_r;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual kind %0d byte %0h",
                   $time, out_ch.kind, out_ch.tx_byte);
        end else begin
          want_r = pending_results.pop_front();
          check_field("kind", want_r.kind, out_ch.kind);
          check_field("tx_byte", want_r.tx, out_ch.tx_byte);
          check_field("last", want_r.last, out_ch.last);
          check_field("relay_drive", want_r.drive, out_ch.relay_drive);
          check_field("on_air", {want_r.air}, {out_ch.on_air});
          results_checked++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == stp_pkg::CFG_DEVICE_ID) dev_id = cfg_ch.data[6:0];
        else if (cfg_ch.index == stp_pkg::CFG_RELAY_ACTIVE_LOW) act_low = cfg_ch.data[0];
      end
      if (in_ch.valid && in_ch.ready) begin
        tally_predict(in_ch.func, in_ch.rx_byte);
        if (cur_typed) begin
          pending_results = {pending_results, cur_typed_res};
          updates_expected++;
        end else begin
          foreach (step_results[i]) begin
            pending_results = {pending_results, step_results[i]};
            if (step_results[i].kind == stp_pkg::KIND_UPDATE) updates_expected++;
          end
        end
      end
    end
  end

  // Receiver: random ready pattern, with a long hold-off on request.
  int hold_left = 0;
  int run_left  = 0;
  int idle_left = 0;
  logic rdy;
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
      end else if (idle_left > 0) begin
        rdy = 1'b0;
        idle_left--;
      end else if (run_left > 0) begin
        rdy = 1'b1;
        run_left--;
      end else begin
        run_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(0, 6);
        idle_left = rand_gap();
        rdy       = (idle_left == 0);
      end
      out_ch.ready = rdy;
    end
  end

  // Cycle counter guarding against a hang.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sysex_tally_poll_decoder_top: mismatch");
    $finish;
  end

  // Offer one input transaction after a random gap and wait for it to be taken.
  task automatic send_item(input logic func, input logic [7:0] b, input logic typed,
                           input tally_result_t res);
    int gap;
    gap = (burst_left > 0) ? 0 : rand_gap();
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.func    = func;
    in_ch.rx_byte = b;
    cur_typed     = typed;
    cur_typed_res = res;
    in_ch.valid   = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_rx(input logic [7:0] b);
    send_item(stp_pkg::FUNC_RX, b, 1'b0, '0);
  endtask

  task automatic send_poll();
    send_item(stp_pkg::FUNC_POLL, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // Pause the sender until every expected result has arrived and the block is quiet.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    cfg_writes++;
  endtask

  // A tally reply with random content; now and then the minimal length or a long tail.
  task automatic send_reply();
    logic [7:0] frame [$];
    logic [7:0] ch;
    logic [7:0] st;
    logic [7:0] cmd;
    int r;
    int trail;
    ch  = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 7))
                                       : 8'($urandom_range(8, 255));
    r   = $urandom_range(0, 99);
    st  = (r < 40) ? stp_pkg::STATUS_ON : (r < 80) ? 8'h00 : 8'($urandom_range(0, 255));
    cmd = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : stp_pkg::CMD_DT1;
    frame = '{stp_pkg::SYX_START, stp_pkg::MFR_ID, 8'($urandom_range(0, 127)),
              stp_pkg::ZERO_BYTE, stp_pkg::ZERO_BYTE, stp_pkg::ZERO_BYTE, stp_pkg::MODEL_ID,
              cmd, stp_pkg::ADDR_HI, stp_pkg::ZERO_BYTE, ch};
    if ($urandom_range(0, 9) != 0) begin
      frame = {frame, st};
      trail = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 26) : $urandom_range(0, 3);
      repeat (trail) frame = {frame, 8'($urandom_range(0, 127))};
    end
    frame = {frame, stp_pkg::SYX_END};
    foreach (frame[i]) send_rx(frame[i]);
  endtask

  // A frame of random bytes, possibly unterminated or longer than the position counter.
  task automatic send_broken();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 14);
    send_rx(stp_pkg::SYX_START);
    repeat (n) send_rx(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1) == 1) send_rx(stp_pkg::SYX_END);
  endtask

  task automatic run_random(input int unsigned target);
    int r;
    while (items_sent < target) begin
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 30);
      r = $urandom_range(0, 99);
      if (r < 25) send_poll();
      else if (r < 80) send_reply();
      else if (r < 90) repeat ($urandom_range(1, 3)) send_rx(8'($urandom_range(0, 255)));
      else send_broken();
    end
  endtask

  // Stimulus: reset, directed table, then random phases under several register settings.
  int unsigned phase_target;
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.func    = stp_pkg::FUNC_POLL;
    in_ch.rx_byte = 8'h00;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = stp_pkg::CFG_DEVICE_ID;
    cfg_ch.data   = 8'h00;
    cur_typed     = 1'b0;
    cur_typed_res = '0;

    dev_id     = stp_pkg::DEVICE_ID_RST;
    act_low    = stp_pkg::RELAY_ACTIVE_LOW_RST;
    poll_ch    = '0;
    in_msg     = 1'b0;
    byte_pos   = 5'd0;
    cmd_b      = 8'h00;
    rep_ch     = 8'h00;
    rep_st     = 8'h00;
    on_air_idx = stp_pkg::ON_AIR_NONE;
    for (int i = 0; i < stp_pkg::NUM_CHANNELS; i++) begin
      ch_status[i] = 8'h00;
      ch_known[i]  = 1'b0;
    end

    // Stray bytes, a short reply, a restart inside a frame, a real-time byte
    // counted as data, and a minimal reply whose end byte fills the status slot.
    dir_table = '{
      '{stp_pkg::FUNC_POLL, 8'h00,              1'b0, '0},
      '{stp_pkg::FUNC_RX,   stp_pkg::SYX_END,   1'b0, '0},
      '{stp_pkg::FUNC_RX,   8'h55,              1'b0, '0},
      '{stp_pkg::FUNC_RX,   stp_pkg::SYX_START, 1'b0, '0},
      '{stp_pkg::FUNC_RX,   stp_pkg::CMD_DT1,   1'b0, '0},
      '{stp_pkg::FUNC_RX,   stp_pkg::SYX_END,   1'b0, '0},
      '{stp_pkg::FUNC_RX,   stp_pkg::SYX_START, 1'b0, '0},
      '{stp_pkg::FUNC_RX,   stp_pkg::MFR_ID,    1'b0, '0},
      '{stp_pkg::FUNC_RX,   stp_pkg::SYX_START, 1'b0, '0},
      '{stp_pkg::FUNC_RX,   stp_pkg::MFR_ID,    1'b0, '0},
      '{stp_pkg::FUNC_RX,   8'h10,              1'b0, '0},
      '{stp_pkg::FUNC_RX,   stp_pkg::ZERO_BYTE, 1'b0, '0},
      '{stp_pkg::FUNC_RX,   stp_pkg::ZERO_BYTE, 1'b0, '0},
      '{stp_pkg::FUNC_RX,   stp_pkg::ZERO_BYTE, 1'b0, '0},
      '{stp_pkg::FUNC_RX,   stp_pkg::MODEL_ID,  1'b0, '0},
      '{stp_pkg::FUNC_RX,   stp_pkg::CMD_DT1,   1'b0, '0},
      '{stp_pkg::FUNC_RX,   stp_pkg::ADDR_HI,   1'b0, '0},
      '{stp_pkg::FUNC_RX,   MIDI_CLOCK,         1'b0, '0},
      '{stp_pkg::FUNC_RX,   8'h07,              1'b0, '0},
      '{stp_pkg::FUNC_RX,   stp_pkg::SYX_END,   1'b1,
        '{stp_pkg::KIND_UPDATE, 8'h00, 1'b1, 8'hFF, stp_pkg::ON_AIR_NONE}},
      '{stp_pkg::FUNC_POLL, 8'hFF,              1'b0, '0},
      '{stp_pkg::FUNC_RX,   8'hFF,              1'b0, '0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_table[i]) begin
      send_item(dir_table[i].func, dir_table[i].rx, dir_table[i].typed, dir_table[i].res);
    end
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          cfg_write(stp_pkg::CFG_DEVICE_ID, 8'h00);
          cfg_write(stp_pkg::CFG_RELAY_ACTIVE_LOW, 8'h00);
        end
        1: begin
          cfg_write(stp_pkg::CFG_DEVICE_ID, 8'hFF);
          cfg_write(stp_pkg::CFG_RELAY_ACTIVE_LOW, 8'hFF);
        end
        2: begin
          cfg_write(stp_pkg::CFG_DEVICE_ID, 8'($urandom_range(0, 255)));
          cfg_write(stp_pkg::CFG_RELAY_ACTIVE_LOW, 8'($urandom_range(0, 255)));
          cfg_write(CFG_SPARE_A, 8'($urandom_range(0, 255)));
          cfg_write(CFG_SPARE_B, 8'($urandom_range(0, 255)));
        end
        default: begin
          cfg_write(stp_pkg::CFG_DEVICE_ID, 8'($urandom_range(0, 127)));
          cfg_write(stp_pkg::CFG_RELAY_ACTIVE_LOW, {7'($urandom_range(0, 127)), 1'b0});
        end
      endcase

      // Hold the receiver off while polls keep coming, so the queue fills and the input stalls.
      if (p == 1) begin
        hold_req = HOLD_OFF;
        repeat (12) begin
          burst_left = 1;
          send_poll();
        end
      end

      phase_target = DIR_ROWS + 107 * (p + 1);
      run_random(phase_target);
      wait_drained();
    end

    $display("Covered %0d input transactions and %0d checked results (%0d relay updates),",
             items_sent, results_checked, updates_expected);
    $display("across %0d register writes with both relay polarities and extreme device ids.",
             cfg_writes);
    if (errors == 0) begin
      $display("sysex_tally_poll_decoder_top: match");
    end else begin
      $display("sysex_tally_poll_decoder_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- sysex_tally_poll_decoder_top.f -----
src/stp_pkg.sv
src/stp_in_if.sv
src/stp_out_if.sv
src/stp_cfg_if.sv
src/stp_front.sv
src/stp_queue.sv
src/stp_back.sv
src/sysex_tally_poll_decoder_top.sv
tb/sv/sysex_tally_poll_decoder_top_test.sv
